### design/oaht_pkg.sv
package oaht_pkg;

  localparam int SLOTS      = 256;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;
  localparam int USED_W     = IDX_W + 1;
  localparam int LIMIT_W    = 8;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

  // request kinds
  localparam logic [1:0] KIND_GET = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_UPDATE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch request, start probe
    logic probe;   // examine one slot
    logic update;  // write back, emit result
  } oaht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic probe_done;
  } oaht_stat_t;

endpackage

### design/oaht_ctrl.sv
module oaht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  oaht_pkg::oaht_stat_t stat,
  output oaht_pkg::oaht_cmd_t  cmd,
  output logic               busy
);
  import oaht_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (stat.probe_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

### design/oaht_datapath.sv
module oaht_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oaht_pkg::oaht_cmd_t                cmd,
  output oaht_pkg::oaht_stat_t               stat,
  input  logic [1:0]                         in_kind,
  input  logic [31:0]                        in_key_id,
  input  logic [31:0]                        in_key_hash,
  input  logic [63:0]                        in_new_value,
  input  logic                               cfg_we,
  input  logic [oaht_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [63:0]                        out_read_value,
  output logic                               out_status
);
  import oaht_pkg::*;

  typedef enum logic [1:0] {
    MARK_EMPTY,
    MARK_LIVE,
    MARK_TOMB
  } mark_t;

  typedef struct packed {
    mark_t               mark;
    logic [KEY_BITS-1:0] key;
  } meta_t;

  // slot store: mark+key and value, one read and one write port each
  meta_t                 meta_mem [SLOTS];
  logic [VALUE_BITS-1:0] data_mem [SLOTS];
  logic [SLOTS-1:0]      vld_r;   // slot ever written; clear == empty

  meta_t                 meta_q;
  logic [VALUE_BITS-1:0] data_q;
  logic                  vld_q;

  // request
  logic [1:0]            kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // probe state
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      cnt_r;
  logic                  tomb_seen_r;
  logic [IDX_W-1:0]      tomb_at_r;

  // probe outcome
  logic                  found_r, has_slot_r, is_empty_r;
  logic [IDX_W-1:0]      at_r;
  logic [VALUE_BITS-1:0] hit_data_r;

  logic [LIMIT_W-1:0]    limit_r;
  logic [USED_W-1:0]     used_r;

  logic                  out_valid_r, out_hit_r, out_status_r;
  logic [63:0]           out_rd_r;

  mark_t                 mark_cur;
  logic                  is_e, is_match, is_tomb, last, done;
  logic                  found_nxt, has_slot_nxt, is_empty_nxt;
  logic [IDX_W-1:0]      at_nxt;
  logic [USED_W:0]       used_plus;
  logic                  over_limit, ins_ok;
  logic                  meta_we, data_we, used_inc;
  meta_t                 meta_wdata;
  logic                  res_hit, res_status;
  logic [63:0]           res_rd;

  // read address runs one slot ahead of the slot being examined
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = in_key_hash[IDX_W-1:0];
    end else if (cmd.probe) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    meta_q <= meta_mem[idx_nxt];
    data_q <= data_mem[idx_nxt];
    vld_q  <= vld_r[idx_nxt];
    if (meta_we) meta_mem[at_r] <= meta_wdata;
    if (data_we) data_mem[at_r] <= val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (meta_we) begin
      vld_r[at_r] <= 1'b1;
    end
  end

  // slot examine
  always_comb begin
    mark_cur = vld_q ? meta_q.mark : MARK_EMPTY;
    is_e     = (mark_cur == MARK_EMPTY);
    is_match = (mark_cur == MARK_LIVE) && (meta_q.key == key_r);
    is_tomb  = !is_e && (mark_cur != MARK_LIVE);
    last     = (cnt_r == IDX_W'(SLOTS - 1));
    done     = is_e || is_match || last;

    found_nxt    = 1'b0;
    has_slot_nxt = 1'b0;
    is_empty_nxt = 1'b0;
    at_nxt       = idx_r;
    if (is_match) begin
      found_nxt    = 1'b1;
      has_slot_nxt = 1'b1;
    end else if (is_e) begin
      has_slot_nxt = 1'b1;
      if (tomb_seen_r) begin
        at_nxt = tomb_at_r;
      end else begin
        is_empty_nxt = 1'b1;
      end
    end else begin
      // full sweep without key or empty slot
      has_slot_nxt = tomb_seen_r || is_tomb;
      if (tomb_seen_r) at_nxt = tomb_at_r;
    end
  end

  assign stat.probe_done = done;

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      kind_r      <= in_kind;
      key_r       <= in_key_id[KEY_BITS-1:0];
      val_r       <= in_new_value[VALUE_BITS-1:0];
      cnt_r       <= '0;
      tomb_seen_r <= 1'b0;
      tomb_at_r   <= '0;
    end else if (cmd.probe) begin
      cnt_r <= cnt_r + IDX_W'(1);
      if (is_tomb && !tomb_seen_r) begin
        tomb_seen_r <= 1'b1;
        tomb_at_r   <= idx_r;
      end
      if (done) begin
        found_r    <= found_nxt;
        has_slot_r <= has_slot_nxt;
        is_empty_r <= is_empty_nxt;
        at_r       <= at_nxt;
        hit_data_r <= data_q;
      end
    end
  end

  // write-back decision
  always_comb begin
    used_plus  = {1'b0, used_r} + (USED_W + 1)'(1);
    over_limit = used_plus > (USED_W + 1)'(limit_r);
    ins_ok     = !found_r && has_slot_r && !(is_empty_r && over_limit);

    meta_we  = cmd.update &&
               (((kind_r == KIND_SET) && ins_ok) || ((kind_r == KIND_DEL) && found_r));
    data_we  = cmd.update && (kind_r == KIND_SET) && (found_r || ins_ok);
    used_inc = cmd.update && (kind_r == KIND_SET) && ins_ok && is_empty_r;

    meta_wdata.mark = (kind_r == KIND_DEL) ? MARK_TOMB : MARK_LIVE;
    meta_wdata.key  = key_r;

    res_hit    = 1'b0;
    res_status = 1'b0;
    res_rd     = '0;
    case (kind_r)
      KIND_GET: begin
        res_hit = found_r;
        if (found_r) res_rd = 64'(hit_data_r);
      end
      KIND_SET: begin
        res_hit    = ins_ok;
        res_status = !found_r && !ins_ok;
      end
      KIND_DEL: begin
        res_hit = found_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LOAD_LIMIT_RST;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (used_inc) used_r <= used_r + USED_W'(1);
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r    <= res_hit;
      out_status_r <= res_status;
      out_rd_r     <= res_rd;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;

endmodule

### design/open_addressing_hash_table_unit.sv
// Key/value table, 256 slots, open addressing with linear probing and
// tombstones. Pulse start while busy is low to issue a get, set or delete;
// the request is taken at that edge. The probe walks one slot per cycle from
// (key_hash mod 256) through the single read port of the slot memory and
// visits 1 to 256 slots; busy stays high through the probe and update states,
// and the next request is taken once busy is low again. The result shows
// on the out_ ports for exactly one cycle, flagged by out_valid, in the
// cycle right after busy drops; the receiver cannot stall it, so capture it
// then. A new start may be taken in that same cycle. Slots read as empty
// straight out of reset (per-slot valid flops), no clearing pass. cfg_we
// writes load_limit (reset 192); only write it while the unit is idle.
module open_addressing_hash_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request beat
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key_id,
  input  logic [31:0] in_key_hash,
  input  logic [63:0] in_new_value,
  // result beat
  output logic        out_valid,
  output logic        out_hit,
  output logic [63:0] out_read_value,
  output logic        out_status,
  // load limit register
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  import oaht_pkg::*;

  oaht_cmd_t  cmd;
  oaht_stat_t stat;

  // sequencer: idle -> probe (one slot/cycle) -> update/result
  oaht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // slot memories, probe tracking, occupancy count, result regs
  oaht_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_key_id      (in_key_id),
    .in_key_hash    (in_key_hash),
    .in_new_value   (in_new_value),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

  // a result beat only follows an update cycle
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a request in flight");

  // an accepted request always makes the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  // refused set never reports hit; data only with a hit
  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_hit && out_status) && (out_hit || (out_read_value == 64'd0))))
    else $error("inconsistent result fields");

endmodule
